>>> design/assert_macros.svh
// Assertion macros shared by the converter modules.
// No dependencies; each file that asserts includes this header.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent implies consequent in the following cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/abln_pkg.sv
// Shared types and constants for the Annex-B to length-prefixed NAL converter.
// No dependencies; used by every module of the block but abln_fifo.
package abln_pkg;

    localparam int LENGTH_BITS_DEF = 32;
    localparam int OP_DEPTH_DEF    = 4;
    localparam int OUT_DEPTH_DEF   = 4;

    localparam logic [1:0] KIND_PAYLOAD = 2'd0;
    localparam logic [1:0] KIND_LENGTH  = 2'd1;
    localparam logic [1:0] KIND_STATUS  = 2'd2;

    localparam logic [4:0] NAL_TYPE_MASK = 5'h1F;
    localparam logic [4:0] NAL_TYPE_SPS  = 5'd7;
    localparam logic [4:0] NAL_TYPE_PPS  = 5'd8;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       unit_end;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  record_kind;
        logic [7:0]  payload_byte;
        logic [31:0] nal_byte_count;
        logic [4:0]  nal_unit_type;
        logic        unit_failed;
        logic        final_record;
    } t_out_item;

    // Steps passed from the front part to the back part.
    typedef enum logic [1:0] {
        OP_TAKE  = 2'd0,
        OP_START = 2'd1,
        OP_CLOSE = 2'd2,
        OP_END   = 2'd3
    } t_op_code;

    typedef struct packed {
        t_op_code   code;
        logic [7:0] data;
    } t_op;

endpackage

>>> design/abln_fifo.sv
// Small register FIFO used for the step queue and the result queue.
// Depends on assert_macros.svh; DEPTH must be a power of two, at least 2.
`include "assert_macros.svh"

module abln_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [0:DEPTH-1];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             wr_en;
    logic             rd_en;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign wr_en   = i_push & ~o_full;
    assign rd_en   = i_pop & ~o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (wr_en) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(1);
            end
            if (rd_en) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
            unique case ({wr_en, rd_en})
                2'b10: begin
                    r_count <= r_count + CNT_W'(1);
                end
                2'b01: begin
                    r_count <= r_count - CNT_W'(1);
                end
                default: begin
                    r_count <= r_count;
                end
            endcase
        end
    end

    `ASSERT_ALWAYS(a_fifo_count, i_clk, i_rst_n, r_count <= CNT_W'(DEPTH), "fifo overfilled")

endmodule

>>> design/abln_front.sv
// Front part: lookahead window, start-code detection, step generation.
// Depends on abln_pkg and assert_macros.svh.
`include "assert_macros.svh"

module abln_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    output logic                o_full,
    input  abln_pkg::t_in_item  i_item,
    output logic                o_op_push,
    output abln_pkg::t_op       o_op,
    input  logic                i_op_full
);

    localparam logic [2:0] SC_NONE  = 3'd0;
    localparam logic [2:0] SC_SHORT = 3'd3;
    localparam logic [2:0] SC_LONG  = 3'd4;
    localparam logic [2:0] WIN_FULL = 3'd4;

    typedef enum logic [3:0] {
        ST_RUN   = 4'b0001,
        ST_DRAIN = 4'b0010,
        ST_CLOSE = 4'b0100,
        ST_END   = 4'b1000
    } t_front_state;

    function automatic logic [2:0] sc_len(input logic [7:0] b0, input logic [7:0] b1,
                                          input logic [7:0] b2, input logic [7:0] b3,
                                          input logic [2:0] avail);
        logic [2:0] res;
        res = SC_NONE;
        if (avail >= 3'd4 && b0 == 8'h00 && b1 == 8'h00 && b2 == 8'h00 && b3 == 8'h01) begin
            res = SC_LONG;
        end else if (avail >= 3'd3 && b0 == 8'h00 && b1 == 8'h00 && b2 == 8'h01) begin
            res = SC_SHORT;
        end
        return res;
    endfunction

    t_front_state r_state, n_state;
    logic [7:0]   r_look [0:2];
    logic [7:0]   n_look [0:2];
    logic [1:0]   r_fill, n_fill;
    logic [7:0]   r_win [0:3];
    logic [7:0]   n_win [0:3];
    logic [2:0]   r_wcnt, n_wcnt;

    logic         accept;
    logic [2:0]   run_sc;
    logic [2:0]   drn_sc;
    logic [2:0]   drn_step;
    logic [2:0]   wcnt_left;

    assign o_full    = (r_state != ST_RUN) | i_op_full;
    assign accept    = i_push & ~o_full;
    assign run_sc    = sc_len(r_look[0], r_look[1], r_look[2], i_item.data_byte, WIN_FULL);
    assign drn_sc    = sc_len(r_win[0], r_win[1], r_win[2], r_win[3], r_wcnt);
    assign drn_step  = (drn_sc != SC_NONE) ? drn_sc : 3'd1;
    assign wcnt_left = r_wcnt - drn_step;

    always_comb begin
        n_state   = r_state;
        n_look    = r_look;
        n_fill    = r_fill;
        n_win     = r_win;
        n_wcnt    = r_wcnt;
        o_op_push = 1'b0;
        o_op.code = abln_pkg::OP_TAKE;
        o_op.data = 8'h00;
        unique case (r_state)
            ST_RUN: begin
                if (accept) begin
                    if (i_item.unit_end) begin
                        // last byte: freeze the whole window for draining
                        for (int i = 0; i < 4; i++) begin
                            if (2'(i) < r_fill && i < 3) begin
                                n_win[i] = r_look[i];
                            end else if (2'(i) == r_fill) begin
                                n_win[i] = i_item.data_byte;
                            end else begin
                                n_win[i] = 8'h00;
                            end
                        end
                        n_wcnt  = {1'b0, r_fill} + 3'd1;
                        n_fill  = 2'd0;
                        n_state = ST_DRAIN;
                    end else if (r_fill != 2'd3) begin
                        n_look[r_fill] = i_item.data_byte;
                        n_fill         = r_fill + 2'd1;
                    end else if (run_sc == SC_LONG) begin
                        o_op_push = 1'b1;
                        o_op.code = abln_pkg::OP_START;
                        n_fill    = 2'd0;
                    end else if (run_sc == SC_SHORT) begin
                        o_op_push = 1'b1;
                        o_op.code = abln_pkg::OP_START;
                        n_look[0] = i_item.data_byte;
                        n_fill    = 2'd1;
                    end else begin
                        o_op_push = 1'b1;
                        o_op.code = abln_pkg::OP_TAKE;
                        o_op.data = r_look[0];
                        n_look[0] = r_look[1];
                        n_look[1] = r_look[2];
                        n_look[2] = i_item.data_byte;
                    end
                end
            end
            ST_DRAIN: begin
                if (!i_op_full) begin
                    o_op_push = 1'b1;
                    if (drn_sc != SC_NONE) begin
                        o_op.code = abln_pkg::OP_START;
                    end else begin
                        o_op.code = abln_pkg::OP_TAKE;
                        o_op.data = r_win[0];
                    end
                    unique case (drn_step)
                        3'd1: begin
                            n_win[0] = r_win[1];
                            n_win[1] = r_win[2];
                            n_win[2] = r_win[3];
                            n_win[3] = 8'h00;
                        end
                        3'd3: begin
                            n_win[0] = r_win[3];
                            n_win[1] = 8'h00;
                            n_win[2] = 8'h00;
                            n_win[3] = 8'h00;
                        end
                        default: begin
                            n_win[0] = 8'h00;
                            n_win[1] = 8'h00;
                            n_win[2] = 8'h00;
                            n_win[3] = 8'h00;
                        end
                    endcase
                    n_wcnt = wcnt_left;
                    if (wcnt_left == 3'd0) begin
                        n_state = ST_CLOSE;
                    end
                end
            end
            ST_CLOSE: begin
                if (!i_op_full) begin
                    o_op_push = 1'b1;
                    o_op.code = abln_pkg::OP_CLOSE;
                    n_state   = ST_END;
                end
            end
            ST_END: begin
                if (!i_op_full) begin
                    o_op_push = 1'b1;
                    o_op.code = abln_pkg::OP_END;
                    n_state   = ST_RUN;
                end
            end
            default: begin
                n_state = ST_RUN;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_RUN;
            r_fill  <= 2'd0;
            r_wcnt  <= 3'd0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            r_wcnt  <= n_wcnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_look <= n_look;
        r_win  <= n_win;
    end

    `ASSERT_IMPLIES(a_drain_cnt, i_clk, i_rst_n, r_state == ST_DRAIN, r_wcnt != 3'd0 && r_wcnt <= 3'd4, "drain window count out of range")
    `ASSERT_NEXT(a_last_drain, i_clk, i_rst_n, accept && i_item.unit_end, r_state == ST_DRAIN && r_fill == 2'd0, "last byte did not start drain")

endmodule

>>> design/abln_back.sv
// Back part: NAL state, byte counting, record generation.
// Depends on abln_pkg and assert_macros.svh.
`include "assert_macros.svh"

module abln_back #(
    parameter int LENGTH_BITS = abln_pkg::LENGTH_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_op_valid,
    input  abln_pkg::t_op       i_op,
    output logic                o_op_pop,
    input  logic                i_out_full,
    output logic                o_out_push,
    output abln_pkg::t_out_item o_record
);

    logic                   r_inside, n_inside;
    logic [LENGTH_BITS-1:0] r_len, n_len;
    logic [4:0]             r_type, n_type;
    logic                   r_drop, n_drop;
    logic                   r_emitted, n_emitted;

    logic                   process;
    logic                   len_zero;
    logic                   close_emit;
    logic [4:0]             take_type;
    logic                   take_drop;
    logic                   eff_drop;

    assign process    = i_op_valid & ~i_out_full;
    assign o_op_pop   = process;
    assign len_zero   = (r_len == '0);
    assign close_emit = r_inside & ~len_zero & ~r_drop;
    assign take_type  = i_op.data[4:0] & abln_pkg::NAL_TYPE_MASK;
    assign take_drop  = (take_type == abln_pkg::NAL_TYPE_SPS) ||
                        (take_type == abln_pkg::NAL_TYPE_PPS);
    assign eff_drop   = len_zero ? take_drop : r_drop;

    always_comb begin
        n_inside   = r_inside;
        n_len      = r_len;
        n_type     = r_type;
        n_drop     = r_drop;
        n_emitted  = r_emitted;
        o_out_push = 1'b0;
        o_record   = '0;
        if (process) begin
            unique case (i_op.code)
                abln_pkg::OP_TAKE: begin
                    if (r_inside) begin
                        if (len_zero) begin
                            n_type = take_type;
                            n_drop = take_drop;
                        end
                        if (!eff_drop) begin
                            o_out_push            = 1'b1;
                            o_record.record_kind  = abln_pkg::KIND_PAYLOAD;
                            o_record.payload_byte = i_op.data;
                        end
                        // count saturates; bytes still pass
                        if (r_len != '1) begin
                            n_len = r_len + LENGTH_BITS'(1);
                        end
                    end
                end
                abln_pkg::OP_START: begin
                    if (close_emit) begin
                        o_out_push              = 1'b1;
                        o_record.record_kind    = abln_pkg::KIND_LENGTH;
                        o_record.nal_byte_count = 32'(r_len);
                        o_record.nal_unit_type  = r_type;
                        n_emitted               = 1'b1;
                    end
                    n_inside = 1'b1;
                    n_len    = '0;
                    n_type   = 5'd0;
                    n_drop   = 1'b0;
                end
                abln_pkg::OP_CLOSE: begin
                    if (close_emit) begin
                        o_out_push              = 1'b1;
                        o_record.record_kind    = abln_pkg::KIND_LENGTH;
                        o_record.nal_byte_count = 32'(r_len);
                        o_record.nal_unit_type  = r_type;
                        n_emitted               = 1'b1;
                    end
                end
                abln_pkg::OP_END: begin
                    o_out_push            = 1'b1;
                    o_record.record_kind  = abln_pkg::KIND_STATUS;
                    o_record.unit_failed  = ~r_emitted;
                    o_record.final_record = 1'b1;
                    n_inside              = 1'b0;
                    n_len                 = '0;
                    n_type                = 5'd0;
                    n_drop                = 1'b0;
                    n_emitted             = 1'b0;
                end
                default: begin
                    n_inside = r_inside;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inside  <= 1'b0;
            r_len     <= '0;
            r_type    <= 5'd0;
            r_drop    <= 1'b0;
            r_emitted <= 1'b0;
        end else begin
            r_inside  <= n_inside;
            r_len     <= n_len;
            r_type    <= n_type;
            r_drop    <= n_drop;
            r_emitted <= n_emitted;
        end
    end

    `ASSERT_IMPLIES(a_end_record, i_clk, i_rst_n, process && i_op.code == abln_pkg::OP_END, o_out_push && o_record.final_record, "end step gave no final record")
    `ASSERT_NEXT(a_end_clears, i_clk, i_rst_n, process && i_op.code == abln_pkg::OP_END, !r_inside && !r_emitted && r_len == '0, "unit state not cleared")
    `ASSERT_IMPLIES(a_len_nonzero, i_clk, i_rst_n, o_out_push && o_record.record_kind == abln_pkg::KIND_LENGTH, o_record.nal_byte_count != 32'd0, "empty NAL reported")

endmodule

>>> design/annexb_to_length_prefixed_nal_core.sv
// Top level of the Annex-B to length-prefixed NAL converter.
// Depends on abln_pkg, abln_fifo, abln_front and abln_back.
//
// Takes an H.264 Annex-B access unit one byte per transfer (unit_end on the
// last byte) and emits a stream of records: payload bytes of every kept NAL,
// a length record (count saturating at 2^LENGTH_BITS-1, plus NAL type) when
// each NAL closes, and a final status record flagging a unit that produced
// no NAL. SPS/PPS and empty NALs are dropped; a writer puts each length as a
// 4-byte big-endian prefix ahead of its NAL. Both sides look like queues:
// push/full in, empty/pop out. Ordinary bytes are taken one per clock while
// the step queue has room; the front keeps a three-byte lookahead, issues
// at most one step per ordinary byte to a short step queue, and the back
// turns one step per clock into at most one record in the result queue
// while that queue has room. After a transfer carrying unit_end, full stays
// high through s drain steps over the n = 1..4 bytes left in the window
// (one step per plain byte, one per start code, so 1 <= s <= n), then the
// close and end steps. A full step queue stalls the input further. A record
// reaches the outputs through both queues; a payload byte is released by the
// transfer three bytes later, or by the drain after the unit's last byte.

module annexb_to_length_prefixed_nal_core #(
    parameter int LENGTH_BITS = abln_pkg::LENGTH_BITS_DEF,
    parameter int OP_DEPTH    = abln_pkg::OP_DEPTH_DEF,
    parameter int OUT_DEPTH   = abln_pkg::OUT_DEPTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                push,
    output logic                full,
    input  abln_pkg::t_in_item  i_item,
    output logic                empty,
    input  logic                pop,
    output abln_pkg::t_out_item o_record
);

    localparam int OP_W  = $bits(abln_pkg::t_op);
    localparam int OUT_W = $bits(abln_pkg::t_out_item);

    // front -> step queue
    logic                op_push;
    abln_pkg::t_op       op_in;
    logic                op_full;
    // step queue -> back
    logic [OP_W-1:0]     op_head;
    logic                op_empty;
    logic                op_pop;
    // back -> result queue
    logic                rec_push;
    abln_pkg::t_out_item rec_in;
    logic                rec_full;
    logic [OUT_W-1:0]    rec_head;

    abln_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .o_full    (full),
        .i_item    (i_item),
        .o_op_push (op_push),
        .o_op      (op_in),
        .i_op_full (op_full)
    );

    abln_fifo #(
        .WIDTH (OP_W),
        .DEPTH (OP_DEPTH)
    ) u_op_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (op_push),
        .i_data  (op_in),
        .o_full  (op_full),
        .i_pop   (op_pop),
        .o_data  (op_head),
        .o_empty (op_empty)
    );

    abln_back #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_op_valid (~op_empty),
        .i_op       (abln_pkg::t_op'(op_head)),
        .o_op_pop   (op_pop),
        .i_out_full (rec_full),
        .o_out_push (rec_push),
        .o_record   (rec_in)
    );

    // result queue doubles as the output register stage
    abln_fifo #(
        .WIDTH (OUT_W),
        .DEPTH (OUT_DEPTH)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (rec_push),
        .i_data  (rec_in),
        .o_full  (rec_full),
        .i_pop   (pop),
        .o_data  (rec_head),
        .o_empty (empty)
    );

    assign o_record = abln_pkg::t_out_item'(rec_head);

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for annexb_to_length_prefixed_nal_core: directed and random units.
// Depends on abln_pkg and the core; expected records come from a behavioural converter held here.
module testbench;

    localparam int          LEN_BITS     = abln_pkg::LENGTH_BITS_DEF;
    localparam logic [31:0] LEN_TOP      = 32'((64'd1 << LEN_BITS) - 64'd1);
    localparam int          STALL_LIMIT  = 1000;
    localparam int          RANDOM_ITEMS = 150;
    localparam int          CALM_ITEMS   = 40;
    localparam int          DRAIN_CYCLES = 20;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                push;
    logic                full;
    logic                empty;
    logic                pop;
    abln_pkg::t_in_item  i_item;
    abln_pkg::t_out_item o_record;

    annexb_to_length_prefixed_nal_core i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .push     (push),
        .full     (full),
        .i_item   (i_item),
        .empty    (empty),
        .pop      (pop),
        .o_record (o_record)
    );

    always #1 i_clk = ~i_clk;

    // Behavioural converter state
    logic [7:0]  win_bytes [3];
    int          win_fill;
    logic        nal_open;
    logic [31:0] nal_len;
    logic [4:0]  nal_type;
    logic        nal_drop;
    logic        unit_emitted;

    abln_pkg::t_out_item expected_records [$];
    int          fail_count  = 0;
    int          bytes_sent  = 0;
    int          stuck_cycles = 0;
    bit          in_idle_on  = 1'b1;
    bit          out_idle_on = 1'b1;

    function automatic void clear_converter();
        for (int i = 0; i < 3; i++) win_bytes[i] = 8'h00;
        win_fill     = 0;
        nal_open     = 1'b0;
        nal_len      = 32'd0;
        nal_type     = 5'd0;
        nal_drop     = 1'b0;
        unit_emitted = 1'b0;
    endfunction

    function automatic void add_record(logic [1:0] kind, logic [7:0] pb, logic [31:0] len,
                                       logic [4:0] typ, logic failed, logic fin);
        abln_pkg::t_out_item r;
        r.record_kind    = kind;
        r.payload_byte   = pb;
        r.nal_byte_count = len;
        r.nal_unit_type  = typ;
        r.unit_failed    = failed;
        r.final_record   = fin;
        expected_records = {expected_records, r};
    endfunction

    // Length record for the NAL being closed, unless it is empty or dropped
    function automatic void close_open_nal();
        if (nal_open && nal_len != 32'd0 && !nal_drop) begin
            add_record(abln_pkg::KIND_LENGTH, 8'h00, nal_len, nal_type, 1'b0, 1'b0);
            unit_emitted = 1'b1;
        end
    endfunction

    // One accepted byte: scan the window, emit what is confirmed, keep the rest
    function automatic void convert_byte(logic [7:0] b, logic last);
        logic [7:0] w [4];
        int n;
        int pos;
        int avail;
        int sc;
        n = win_fill;
        for (int i = 0; i < n; i++) w[i] = win_bytes[i];
        w[n] = b;
        n++;
        pos = 0;
        while (pos < n) begin
            avail = n - pos;
            // short of four bytes, a start code can only be judged at the unit's end
            if (!last && avail < 4) break;
            sc = 0;
            if (avail >= 4 && w[pos] == 8'h00 && w[pos+1] == 8'h00 && w[pos+2] == 8'h00 &&
                w[pos+3] == 8'h01) begin
                sc = 4;
            end else if (avail >= 3 && w[pos] == 8'h00 && w[pos+1] == 8'h00 &&
                         w[pos+2] == 8'h01) begin
                sc = 3;
            end
            if (sc != 0) begin
                close_open_nal();
                nal_open = 1'b1;
                nal_len  = 32'd0;
                nal_type = 5'd0;
                nal_drop = 1'b0;
                pos += sc;
            end else begin
                if (nal_open) begin
                    if (nal_len == 32'd0) begin
                        nal_type = w[pos][4:0] & abln_pkg::NAL_TYPE_MASK;
                        nal_drop = (nal_type == abln_pkg::NAL_TYPE_SPS) ||
                                   (nal_type == abln_pkg::NAL_TYPE_PPS);
                    end
                    if (!nal_drop)
                        add_record(abln_pkg::KIND_PAYLOAD, w[pos], 32'd0, 5'd0, 1'b0, 1'b0);
                    if (nal_len != LEN_TOP) nal_len++;
                end
                pos++;
            end
        end
        if (!last) begin
            win_fill = n - pos;
            for (int i = 0; i < 3; i++) win_bytes[i] = (i < win_fill) ? w[pos+i] : 8'h00;
        end else begin
            close_open_nal();
            add_record(abln_pkg::KIND_STATUS, 8'h00, 32'd0, 5'd0, !unit_emitted, 1'b1);
            clear_converter();
        end
    endfunction

    // Input side: optional idle burst, then hold the byte until the transfer happens.
    // push stays high after a transfer so back-to-back bytes never toggle it in one step.
    task automatic send_byte(logic [7:0] b, logic last);
        int gap;
        if (in_idle_on && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 17);
            @(negedge i_clk);
            push   <= 1'b0;
            i_item <= abln_pkg::t_in_item'(9'($urandom_range(0, 511)));
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        push             <= 1'b1;
        i_item.data_byte <= b;
        i_item.unit_end  <= last;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        convert_byte(b, last);
        bytes_sent++;
    endtask

    task automatic send_unit(logic [7:0] unit_bytes [$]);
        for (int i = 0; i < unit_bytes.size(); i++)
            send_byte(unit_bytes[i], i == unit_bytes.size() - 1);
    endtask

    // Leading junk, 3- and 4-byte codes, a stray zero before a 4-byte code,
    // byte extremes, a dropped PPS and a start code in the last three bytes
    task automatic test_start_code_forms();
        logic [7:0] unit_bytes [$];
        unit_bytes = {8'h7A, 8'h00, 8'h00, 8'h01, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01,
                      8'h68, 8'h00, 8'h00, 8'h01};
        send_unit(unit_bytes);
    endtask

    // Units that emit nothing: a lone byte, and a bare start code at the tail
    task automatic test_unit_without_nal();
        logic [7:0] unit_bytes [$];
        unit_bytes = {8'h01};
        send_unit(unit_bytes);
        unit_bytes = {8'h00, 8'h00, 8'h01};
        send_unit(unit_bytes);
    endtask

    // SPS dropped, then a one-byte NAL of type 0 ending the unit
    task automatic test_param_set_drop();
        logic [7:0] unit_bytes [$];
        unit_bytes = {8'h00, 8'h00, 8'h01, 8'h67, 8'h00, 8'h00, 8'h01, 8'h00};
        send_unit(unit_bytes);
    endtask

    // Mostly well-formed units with random content; some noise, some cut short
    task automatic send_random_unit();
        logic [7:0] unit_bytes [$];
        int nals;
        int plen;
        int cut;
        if ($urandom_range(0, 5) == 0) begin
            repeat ($urandom_range(1, 10))
                unit_bytes = {unit_bytes, ($urandom_range(0, 2) == 0 ? 8'h00 :
                              ($urandom_range(0, 1) ? 8'h01 : 8'($urandom_range(0, 255))))};
        end else begin
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 3))
                    unit_bytes = {unit_bytes, 8'($urandom_range(2, 255))};
            nals = $urandom_range(0, 4);
            for (int k = 0; k < nals; k++) begin
                if ($urandom_range(0, 1)) unit_bytes = {unit_bytes, 8'h00};
                unit_bytes = {unit_bytes, 8'h00, 8'h00, 8'h01};
                // now and then an empty NAL: start code straight after start code
                if ($urandom_range(0, 9) != 0) begin
                    case ($urandom_range(0, 5))
                        0:       unit_bytes = {unit_bytes, 8'h67};
                        1:       unit_bytes = {unit_bytes, 8'h68};
                        default: unit_bytes = {unit_bytes, 8'($urandom_range(0, 255))};
                    endcase
                    plen = $urandom_range(0, 8);
                    for (int j = 0; j < plen; j++)
                        unit_bytes = {unit_bytes, ($urandom_range(0, 3) == 0 ? 8'h00 :
                                      8'($urandom_range(0, 255)))};
                end
            end
            if (unit_bytes.size() > 1 && $urandom_range(0, 9) == 0) begin
                cut = $urandom_range(1, unit_bytes.size() - 1);
                while (unit_bytes.size() > cut) void'(unit_bytes.pop_back());
            end
        end
        if (unit_bytes.size() == 0) unit_bytes = {unit_bytes, 8'($urandom_range(0, 255))};
        send_unit(unit_bytes);
    endtask

    task automatic test_random_units();
        int stop_at;
        stop_at = bytes_sent + RANDOM_ITEMS;
        while (bytes_sent < stop_at) send_random_unit();
    endtask

    // Final stretch at full rate on both sides
    task automatic test_back_to_back();
        int stop_at;
        in_idle_on  = 1'b0;
        out_idle_on = 1'b0;
        stop_at = bytes_sent + CALM_ITEMS;
        while (bytes_sent < stop_at) send_random_unit();
    endtask

    function automatic void report_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
            fail_count++;
        end
    endfunction

    // Result side: every transfer is checked against the oldest expectation
    always @(posedge i_clk) begin : check_records
        abln_pkg::t_out_item want;
        if (i_rst_n && pop && !empty) begin
            if (expected_records.size() == 0) begin
                $display("%0t: unexpected record: expected none, actual %p", $time, o_record);
                fail_count++;
            end else begin
                want = expected_records.pop_front();
                report_field("record_kind", want.record_kind, o_record.record_kind);
                report_field("payload_byte", want.payload_byte, o_record.payload_byte);
                report_field("nal_byte_count", want.nal_byte_count, o_record.nal_byte_count);
                report_field("nal_unit_type", want.nal_unit_type, o_record.nal_unit_type);
                report_field("unit_failed", want.unit_failed, o_record.unit_failed);
                report_field("final_record", want.final_record, o_record.final_record);
            end
        end
    end

    // Random stalls of the receiver
    initial begin : drive_pop
        int stall_left;
        stall_left = 0;
        pop = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!out_idle_on)
                stall_left = 0;
            else if (stall_left == 0 && $urandom_range(0, 5) == 0)
                stall_left = $urandom_range(1, 17);
            if (stall_left > 0) begin
                pop <= 1'b0;
                stall_left--;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    // Watchdog: too long without a transfer on either side
    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty)) begin
            stuck_cycles <= 0;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
            if (stuck_cycles >= STALL_LIMIT) begin
                $display("annexb_to_length_prefixed_nal_core regression: fail");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n = 1'b0;
        push    = 1'b0;
        i_item  = '0;
        clear_converter();
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_start_code_forms();
        test_unit_without_nal();
        test_param_set_drop();
        test_random_units();
        test_back_to_back();

        @(negedge i_clk);
        push <= 1'b0;
        while (expected_records.size() != 0) @(posedge i_clk);
        // catch any stray records after the last expected one
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("annexb_to_length_prefixed_nal_core regression: pass");
        else
            $display("annexb_to_length_prefixed_nal_core regression: fail");
        $finish;
    end

endmodule
